// ===== rtl/sac_pkg.sv =====
package sac_pkg;

   localparam int PIX_W      = 12;
   localparam int SAMPLE_W   = 32;
   localparam int MAG_W      = 31;
   localparam int CIDX_W     = 8;
   localparam int RGB_W      = 24;
   localparam int BYTE_W     = 8;
   localparam int MAP_ENTRIES = 256;

   // sum of peak and sample, one bit wider than a sample
   localparam int SUM_W      = SAMPLE_W + 1;
   // 255 * s is (s << 8) - s
   localparam int SCALE_SHIFT = 8;
   localparam int NUM_W      = SAMPLE_W + SCALE_SHIFT;
   localparam int DIV_W      = MAG_W + 1;
   localparam int QUO_W      = CIDX_W;
   localparam int CNT_W      = $clog2(QUO_W + 1);

   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN     = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN_SAT = {1'b1, {(SAMPLE_W-2){1'b0}}, 1'b1};
   localparam logic [CIDX_W-1:0]   ZERO_PEAK_ENTRY = 8'd127;
   localparam logic [CIDX_W-1:0]   BOTTOM_ENTRY    = 8'd0;

   typedef enum logic [1:0] {
      CMD_CMAP_WRITE = 2'd0,
      CMD_LOAD       = 2'd1,
      CMD_RENDER     = 2'd2,
      CMD_NONE       = 2'd3
   } cmd_type;

   typedef struct packed {
      logic               start;
      logic [NUM_W-1:0]   dividend;
      logic [DIV_W-1:0]   divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic               done;
      logic [QUO_W-1:0]   quotient;
   } div_status_type;

endpackage

// ===== rtl/sac_req_if.sv =====
interface sac_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     cmd;
   logic [sac_pkg::PIX_W-1:0]      pixel_index;
   logic signed [sac_pkg::SAMPLE_W-1:0] sample;
   logic [sac_pkg::CIDX_W-1:0]     cmap_index;
   logic [sac_pkg::RGB_W-1:0]      cmap_rgb;

   modport source (output valid, cmd, pixel_index, sample, cmap_index, cmap_rgb,
                   input ready);
   modport sink   (input valid, cmd, pixel_index, sample, cmap_index, cmap_rgb,
                   output ready);
endinterface

// ===== rtl/sac_rsp_if.sv =====
interface sac_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sac_pkg::PIX_W-1:0]     pixel_at;
   logic [sac_pkg::BYTE_W-1:0]    red;
   logic [sac_pkg::BYTE_W-1:0]    green;
   logic [sac_pkg::BYTE_W-1:0]    blue;

   modport source (output valid, pixel_at, red, green, blue, input ready);
   modport sink   (input valid, pixel_at, red, green, blue, output ready);
endinterface

// ===== rtl/sac_divider.sv =====
module sac_divider (
   input  logic                    clock,
   input  logic                    reset,
   input  sac_pkg::div_ctrl_type   ctrl,
   output sac_pkg::div_status_type status
);
   import sac_pkg::*;

   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] den_ff, den_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [NUM_W:0]   diff;

   // restoring division, one quotient bit a cycle, MSB first
   always_comb begin
      diff    = {1'b0, rem_ff} - {1'b0, den_ff};
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         rem_in  = ctrl.dividend;
         den_in  = NUM_W'(ctrl.divisor) << (QUO_W - 1);
         quo_in  = '0;
         cnt_in  = CNT_W'(QUO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[NUM_W]) begin
            rem_in = diff[NUM_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         den_in = den_ff >> 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign status.done     = done_ff;
   assign status.quotient = quo_ff;

endmodule

// ===== rtl/symmetric_autoscale_colormap.sv =====
// Symmetric auto-scaling colour-map renderer.
// req_bus takes command words: colour-map write, sample load, or pixel render.
// rsp_bus returns one word (pixel_at, red, green, blue) for each render whose
// pixel index lies inside the SIDE x SIDE field; other commands return nothing.
// Colour-map writes, loads and out-of-field renders do not make the block
// busy, so it stays ready for the next word.
// A render holds req_bus.ready low while it runs: frame read, peak add,
// x255 scaling, a restoring divide in sac_divider, colour-map read. When
// the peak is zero or the sample lies below minus the peak, the divide is
// skipped and the render goes straight from the scaling step to the
// colour-map read.
// The result sits in an output register; if rsp_bus stalls it is held there,
// further loads and writes are still taken, and the next render waits at its
// last step until the register frees.
// Synchronous reset clears the peak to zero and the control state. The frame
// store and colour map are not cleared and must be written before use.
module symmetric_autoscale_colormap #(
   parameter int SIDE = 64
) (
   input  logic      clock,
   input  logic      reset,
   sac_req_if.sink   req_bus,
   sac_rsp_if.source rsp_bus
);
   import sac_pkg::*;

   localparam int unsigned FIELD_SIZE  = SIDE * SIDE;
   localparam int unsigned FRAME_DEPTH = (FIELD_SIZE > (1 << PIX_W)) ? (1 << PIX_W)
                                                                     : FIELD_SIZE;
   localparam int ADDR_W = $clog2(FRAME_DEPTH);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_READ = 7'b0000010,
      ST_PREP = 7'b0000100,
      ST_MUL  = 7'b0001000,
      ST_DIV  = 7'b0010000,
      ST_LOOK = 7'b0100000,
      ST_SEND = 7'b1000000
   } state_type;

   logic [SAMPLE_W-1:0] frame_mem [FRAME_DEPTH];
   logic [RGB_W-1:0]    cmap_mem  [MAP_ENTRIES];

   state_type           state_ff, state_in;
   logic [MAG_W-1:0]    peak_ff, peak_in;
   logic [PIX_W-1:0]    pix_ff, pix_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CIDX_W-1:0]   entry_ff, entry_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]    rsp_pix_ff, rsp_pix_in;
   logic [RGB_W-1:0]    rsp_rgb_ff, rsp_rgb_in;
   logic [SAMPLE_W-1:0] frame_rd_ff;
   logic [RGB_W-1:0]    cmap_rd_ff;

   logic                accept;
   logic                in_field;
   cmd_type             cmd;
   logic [SAMPLE_W-1:0] sat_sample;
   logic [MAG_W-1:0]    load_mag;
   logic                frame_we;
   logic                cmap_we;
   logic                skip_div;
   logic                rsp_load;
   logic [SAMPLE_W-1:0] sum_mag;

   div_ctrl_type        div_ctrl;
   div_status_type      div_sts;

   sac_divider u_div (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (div_ctrl),
      .status (div_sts)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign cmd           = cmd_type'(req_bus.cmd);
   assign in_field      = (32'(req_bus.pixel_index) < FIELD_SIZE);

   // most negative sample is clipped so that its magnitude fits the peak
   assign sat_sample = (req_bus.sample == SAMPLE_MIN) ? SAMPLE_MIN_SAT : req_bus.sample;
   assign load_mag   = sat_sample[SAMPLE_W-1] ? MAG_W'(-sat_sample)
                                              : sat_sample[MAG_W-1:0];

   assign frame_we = accept && (cmd == CMD_LOAD) && in_field;
   assign cmap_we  = accept && (cmd == CMD_CMAP_WRITE);

   assign sum_mag  = sum_ff[SAMPLE_W-1:0];
   assign skip_div = (peak_ff == '0) || sum_ff[SUM_W-1];
   assign rsp_load = (state_ff == ST_SEND) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      div_ctrl.start    = (state_ff == ST_MUL) && !skip_div;
      div_ctrl.dividend = (NUM_W'(sum_mag) << SCALE_SHIFT) - NUM_W'(sum_mag);
      div_ctrl.divisor  = {peak_ff, 1'b0};
   end

   always_comb begin
      state_in = state_ff;
      peak_in  = peak_ff;
      pix_in   = pix_ff;
      sum_in   = sum_ff;
      entry_in = entry_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && in_field) begin
               unique case (cmd)
                  CMD_LOAD: begin
                     // a load at pixel zero restarts the peak
                     if ((req_bus.pixel_index == '0) || (load_mag > peak_ff)) begin
                        peak_in = load_mag;
                     end
                  end
                  CMD_RENDER: begin
                     pix_in   = req_bus.pixel_index;
                     state_in = ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: state_in = ST_PREP;
         ST_PREP: begin
            sum_in   = {2'b00, peak_ff} + {frame_rd_ff[SAMPLE_W-1], frame_rd_ff};
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (peak_ff == '0) begin
               entry_in = ZERO_PEAK_ENTRY;
               state_in = ST_LOOK;
            end else if (sum_ff[SUM_W-1]) begin
               entry_in = BOTTOM_ENTRY;
               state_in = ST_LOOK;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // quotient saturates at 255 when the sample is above the peak
            if (div_sts.done) begin
               entry_in = div_sts.quotient;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: state_in = ST_SEND;
         ST_SEND: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_pix_in   = rsp_pix_ff;
      rsp_rgb_in   = rsp_rgb_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_pix_in   = pix_ff;
         rsp_rgb_in   = cmap_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pix_ff     <= pix_in;
      sum_ff     <= sum_in;
      entry_ff   <= entry_in;
      rsp_pix_ff <= rsp_pix_in;
      rsp_rgb_ff <= rsp_rgb_in;
   end

   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_mem[req_bus.pixel_index[ADDR_W-1:0]] <= sat_sample;
      end
      frame_rd_ff <= frame_mem[pix_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmap_we) begin
         cmap_mem[req_bus.cmap_index] <= req_bus.cmap_rgb;
      end
      cmap_rd_ff <= cmap_mem[entry_ff];
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.pixel_at = rsp_pix_ff;
   assign rsp_bus.red      = rsp_rgb_ff[3*BYTE_W-1:2*BYTE_W];
   assign rsp_bus.green    = rsp_rgb_ff[2*BYTE_W-1:BYTE_W];
   assign rsp_bus.blue     = rsp_rgb_ff[BYTE_W-1:0];

endmodule

// ===== rtl/sac_checker.sv =====
module sac_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic [1:0]                req_cmd,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [sac_pkg::PIX_W-1:0] rsp_pixel_at,
   input logic [sac_pkg::BYTE_W-1:0] rsp_red,
   input logic [sac_pkg::BYTE_W-1:0] rsp_green,
   input logic [sac_pkg::BYTE_W-1:0] rsp_blue
);
   import sac_pkg::*;

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_at) &&
         $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue))
      else $error("response word changed while stalled");

   a_rst_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a new result only ever follows a busy render
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response appeared without a render in progress");

   // writes, loads and unused words leave the block ready
   a_short_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd != CMD_RENDER) |=> req_ready)
      else $error("block went busy on a non-render word");

endmodule

bind symmetric_autoscale_colormap sac_checker u_sac_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .req_cmd      (req_bus.cmd),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_pixel_at (rsp_bus.pixel_at),
   .rsp_red      (rsp_bus.red),
   .rsp_green    (rsp_bus.green),
   .rsp_blue     (rsp_bus.blue)
);

// ===== test/symmetric_autoscale_colormap_test.sv =====
module symmetric_autoscale_colormap_test;
   import sac_pkg::*;

   localparam int SIDE = 64;
   localparam int FIELD_PIXELS = SIDE * SIDE;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [CIDX_W-1:0] TOP_ENTRY = CIDX_W'(MAP_ENTRIES - 1);

   typedef struct packed {
      logic [PIX_W-1:0]  pixel_at;
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
   } pixel_colour_type;

   logic clock = 1'b0;
   logic reset;

   sac_req_if req_bus ();
   sac_rsp_if rsp_bus ();

   symmetric_autoscale_colormap #(
      .SIDE (SIDE)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #1 clock = ~clock;

   // shadow of the block's state
   logic [SAMPLE_W-1:0] frame_model [FIELD_PIXELS];
   logic [RGB_W-1:0]    colour_model [MAP_ENTRIES];
   logic [MAG_W-1:0]    peak_model;
   bit                  pix_loaded [FIELD_PIXELS];
   logic [PIX_W-1:0]    loaded_pixels [$];

   pixel_colour_type colours_due [$];

   int error_count = 0;
   int items_sent = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   task automatic predict_word(input cmd_type op, input logic [PIX_W-1:0] idx,
                               input logic [SAMPLE_W-1:0] raw,
                               input logic [CIDX_W-1:0] ci,
                               input logic [RGB_W-1:0] rgb);
      logic signed [SAMPLE_W-1:0] x;
      logic [SAMPLE_W-1:0]        negated;
      logic [MAG_W-1:0]           mag;
      longint                     span;
      longint                     quot;
      logic [CIDX_W-1:0]          entry;
      logic [RGB_W-1:0]           colour;
      case (op)
         CMD_CMAP_WRITE: colour_model[ci] = rgb;
         CMD_LOAD: begin
            if (idx < FIELD_PIXELS) begin
               // most negative sample is pulled in by one so |x| fits the peak
               x = (raw == SAMPLE_MIN) ? SAMPLE_MIN_SAT : raw;
               frame_model[idx] = x;
               negated = -x;
               mag = x[SAMPLE_W-1] ? negated[MAG_W-1:0] : x[MAG_W-1:0];
               if (idx == 0 || mag > peak_model) peak_model = mag;
               if (!pix_loaded[idx]) begin
                  pix_loaded[idx] = 1'b1;
                  loaded_pixels.push_back(idx);
               end
            end
         end
         CMD_RENDER: begin
            if (idx < FIELD_PIXELS) begin
               x = frame_model[idx];
               span = 255 * (longint'(peak_model) + longint'(x));
               if (peak_model == 0) entry = ZERO_PEAK_ENTRY;
               else if (span < 0) entry = BOTTOM_ENTRY;
               else begin
                  quot = span / (2 * longint'(peak_model));
                  entry = (quot > TOP_ENTRY) ? TOP_ENTRY : quot[CIDX_W-1:0];
               end
               colour = colour_model[entry];
               colours_due.push_back('{idx, colour[2*BYTE_W +: BYTE_W],
                                      colour[BYTE_W +: BYTE_W], colour[0 +: BYTE_W]});
            end
         end
         default: ;
      endcase
   endtask

   // valid is only dropped on an idle cycle, never between back-to-back words
   task automatic send_word(input cmd_type op, input logic [PIX_W-1:0] idx,
                            input logic [SAMPLE_W-1:0] raw,
                            input logic [CIDX_W-1:0] ci,
                            input logic [RGB_W-1:0] rgb);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_bus.valid       <= 1'b1;
      req_bus.cmd         <= op;
      req_bus.pixel_index <= idx;
      req_bus.sample      <= raw;
      req_bus.cmap_index  <= ci;
      req_bus.cmap_rgb    <= rgb;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_word(op, idx, raw, ci, rgb);
      if (op != CMD_NONE) items_sent++;
   endtask

   task automatic load_pixel(input logic [PIX_W-1:0] idx, input logic [SAMPLE_W-1:0] raw);
      send_word(CMD_LOAD, idx, raw, CIDX_W'($urandom), RGB_W'($urandom));
   endtask

   task automatic render_pixel(input logic [PIX_W-1:0] idx);
      send_word(CMD_RENDER, idx, $urandom, CIDX_W'($urandom), RGB_W'($urandom));
   endtask

   task automatic write_colour(input logic [CIDX_W-1:0] ci, input logic [RGB_W-1:0] rgb);
      send_word(CMD_CMAP_WRITE, PIX_W'($urandom), $urandom, ci, rgb);
   endtask

   task automatic hold_until_drained();
      req_bus.valid <= 1'b0;
      while (colours_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] random_sample();
      logic [SAMPLE_W-1:0] raw;
      logic [SAMPLE_W-1:0] mag;
      int unsigned         width;
      raw = $urandom;
      case ($urandom_range(0, 7))
         0: raw = SAMPLE_MIN;
         1: raw = {1'b0, {(SAMPLE_W-1){1'b1}}};
         2: raw = $urandom_range(0, 2) - 1;
         3: begin
            mag = $urandom_range(0, peak_model);
            raw = $urandom_range(0, 1) ? -mag : mag;
         end
         4, 5: begin
            width = $urandom_range(1, MAG_W);
            mag = $urandom & ((32'd1 << width) - 1);
            raw = $urandom_range(0, 1) ? -mag : mag;
         end
         default: ;
      endcase
      return raw;
   endfunction

   task automatic test_colour_table_fill();
      for (int i = 0; i < MAP_ENTRIES; i++) begin
         if (i == 0) write_colour(CIDX_W'(i), {RGB_W{1'b1}});
         else if (i == MAP_ENTRIES - 1) write_colour(CIDX_W'(i), '0);
         else write_colour(CIDX_W'(i), RGB_W'($urandom));
      end
   endtask

   task automatic test_zero_peak();
      // a zero sample away from the origin leaves the peak at zero
      load_pixel(5, '0);
      render_pixel(5);
      load_pixel(0, '0);
      render_pixel(0);
   endtask

   task automatic test_sample_extremes();
      load_pixel(0, SAMPLE_MIN);
      load_pixel(PIX_W'(FIELD_PIXELS - 1), {1'b0, {(SAMPLE_W-1){1'b1}}});
      load_pixel(1, '0);
      load_pixel(2, '1);
      load_pixel(10, SAMPLE_MIN);
      render_pixel(0);
      render_pixel(PIX_W'(FIELD_PIXELS - 1));
      render_pixel(1);
      render_pixel(2);
      render_pixel(10);
   endtask

   task automatic test_restart_below_samples();
      // restart drops the peak under the stored extremes: both ends clamp
      load_pixel(0, 100);
      render_pixel(PIX_W'(FIELD_PIXELS - 1));
      render_pixel(10);
      render_pixel(2);
      render_pixel(0);
      load_pixel(0, '0);
      render_pixel(PIX_W'(FIELD_PIXELS - 1));
   endtask

   task automatic test_unused_command();
      send_word(CMD_NONE, '0, '0, '0, '0);
      send_word(CMD_NONE, '1, '1, '1, '1);
      render_pixel(PIX_W'(FIELD_PIXELS - 1));
   endtask

   task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                      input int count);
      int stop_at;
      int span;
      send_idle_pct = sender_pct;
      stall_pct = receiver_pct;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 9) < 6) begin
            // a small frame from the origin, then renders over it
            span = $urandom_range(2, 12);
            for (int p = 0; p < span; p++) load_pixel(PIX_W'(p), random_sample());
            for (int p = 0; p < span; p++) render_pixel(PIX_W'($urandom_range(0, span - 1)));
         end else begin
            case ($urandom_range(0, 9))
               0, 1: write_colour(CIDX_W'($urandom), RGB_W'($urandom));
               2: send_word(CMD_NONE, PIX_W'($urandom), $urandom, CIDX_W'($urandom),
                            RGB_W'($urandom));
               3, 4, 5: load_pixel(PIX_W'($urandom_range(0, 1) ? $urandom
                                                               : $urandom_range(0, 31)),
                                   random_sample());
               default: begin
                  if (loaded_pixels.size() == 0) load_pixel(0, random_sample());
                  else render_pixel(loaded_pixels[$urandom_range(0, loaded_pixels.size() - 1)]);
               end
            endcase
         end
      end
   endtask

   // receiver: random stalls, and the check of each colour word taken
   initial begin
      pixel_colour_type due;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (colours_due.size() == 0) begin
               error_count++;
               $error("unexpected colour word for pixel %0d", rsp_bus.pixel_at);
            end else begin
               due = colours_due.pop_front();
               if (rsp_bus.pixel_at !== due.pixel_at) begin
                  error_count++;
                  $error("pixel_at: expected %0d, got %0d", due.pixel_at, rsp_bus.pixel_at);
               end
               if (rsp_bus.red !== due.red) begin
                  error_count++;
                  $error("red: expected %0d, got %0d", due.red, rsp_bus.red);
               end
               if (rsp_bus.green !== due.green) begin
                  error_count++;
                  $error("green: expected %0d, got %0d", due.green, rsp_bus.green);
               end
               if (rsp_bus.blue !== due.blue) begin
                  error_count++;
                  $error("blue: expected %0d, got %0d", due.blue, rsp_bus.blue);
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.cmd         <= CMD_NONE;
      req_bus.pixel_index <= '0;
      req_bus.sample      <= '0;
      req_bus.cmap_index  <= '0;
      req_bus.cmap_rgb    <= '0;
      peak_model = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_colour_table_fill();
      test_zero_peak();
      test_sample_extremes();
      test_restart_below_samples();
      test_unused_command();

      test_random_traffic(0, 0, 80);
      hold_until_drained();
      test_random_traffic(79, 0, 80);
      test_random_traffic(0, 79, 80);
      test_random_traffic(32, 32, 80);

      hold_until_drained();
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== symmetric_autoscale_colormap.f =====
rtl/sac_pkg.sv
rtl/sac_req_if.sv
rtl/sac_rsp_if.sv
rtl/sac_divider.sv
rtl/symmetric_autoscale_colormap.sv
rtl/sac_checker.sv
test/symmetric_autoscale_colormap_test.sv
